FILE: src/gvma_pkg.sv
// Shared types, constants and the GF(2^8) multiply for the region engine.
package gvma_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_BYTES = 8;
   localparam int WORD_W     = BYTE_W * WORD_BYTES;
   localparam int COUNT_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int MODE_W     = 2;

   // Field polynomial x^8+x^4+x^3+x^2+1; the low byte is folded back on overflow
   localparam logic [BYTE_W:0]   GF_POLY   = 9'o435;
   localparam logic [BYTE_W-1:0] GF_REDUCE = GF_POLY[BYTE_W-1:0];

   typedef enum logic [MODE_W-1:0] {
      MODE_MUL    = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_MULADD = 2'd2,
      MODE_DOT    = 2'd3
   } op_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF = 1'b0,
      CSR_MODE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_mode_type              mode;
      logic [BYTE_W-1:0]        coefficient;
   } lane_ctrl_type;

   typedef struct packed {
      logic                     accept;
      logic                     last;
      op_mode_type              mode;
   } merge_ctrl_type;

   // Shift-and-reduce product over the eight bits of b
   function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] aa;
      acc = '0;
      aa  = a;
      for (int i = 0; i < BYTE_W; i++) begin
         if (b[i]) begin
            acc = acc ^ aa;
         end
         if (aa[BYTE_W-1]) begin
            aa = {aa[BYTE_W-2:0], 1'b0} ^ GF_REDUCE;
         end else begin
            aa = {aa[BYTE_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

FILE: src/gvma_channels.sv
// Handshake channel interfaces for the request, response and register ports.
interface gvma_req_if import gvma_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    x_word;
   logic [WORD_W-1:0]    z_word;
   logic [COUNT_W-1:0]   lane_count;
   logic                 last;

   modport source (output valid, x_word, z_word, lane_count, last, input ready);
   modport sink   (input valid, x_word, z_word, lane_count, last, output ready);
endinterface

interface gvma_rsp_if import gvma_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    result_word;
   logic                 is_last;

   modport source (output valid, result_word, is_last, input ready);
   modport sink   (input valid, result_word, is_last, output ready);
endinterface

interface gvma_csr_if import gvma_pkg::*; ();
   logic                     valid;
   logic                     ready;
   csr_index_type            index;
   logic [CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/gf256_vector_mul_add.sv
// Top level of the GF(2^8) region multiply-accumulate engine.
//
// req_ch carries one item per beat: x_word and z_word (byte lane 0 in bits 7:0),
// lane_count (lanes from 0 that take part, above LANES counts as LANES) and last.
// rsp_ch carries result_word and is_last. csr_ch writes coefficient (index 0)
// and op_mode (index 1); it is always ready. The user writes it only while idle;
// the block does not enforce this. Modes 0 to 2 give one response beat per
// request beat. Mode 3 folds x*z of the valid lanes into an internal sum and
// gives one beat, the sum in bits 7:0, only on a request marked last, then clears
// the sum. A response beat is valid in the cycle after its request is taken.
// Throughput: one item per cycle unless rsp_ch stalls; all LANES lane multipliers
// and the merge XOR tree sit in a single stage ahead of the output register.
// Reset clears coefficient, op_mode, the inner-product sum and the output beat.
// While the receiver stalls a waiting response, req_ch.ready drops and the
// response beat holds; ready returns in the cycle the beat is taken.
module gf256_vector_mul_add import gvma_pkg::*; #(
   parameter int LANES = 8
) (
   input  logic          clock,
   input  logic          reset,
   gvma_req_if.sink      req_ch,
   gvma_rsp_if.source    rsp_ch,
   gvma_csr_if.sink      csr_ch
);

   logic [BYTE_W-1:0]               coeff_ff;
   op_mode_type                     mode_ff;
   lane_ctrl_type                   lane_ctrl;
   merge_ctrl_type                  merge_ctrl;
   logic [LANES-1:0][BYTE_W-1:0]    lane_res;
   logic [LANES-1:0][BYTE_W-1:0]    lane_dot;
   logic                            in_ready;
   logic                            req_accept;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
         mode_ff  <= MODE_MUL;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_COEFF: coeff_ff <= csr_ch.data;
            CSR_MODE:  mode_ff  <= op_mode_type'(csr_ch.data[MODE_W-1:0]);
         endcase
      end
   end

   assign lane_ctrl.mode        = mode_ff;
   assign lane_ctrl.coefficient = coeff_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      gvma_lane u_lane (
         .ctrl     (lane_ctrl),
         .lane_en  (req_ch.lane_count > COUNT_W'(l)),
         .x_byte   (req_ch.x_word[l*BYTE_W +: BYTE_W]),
         .z_byte   (req_ch.z_word[l*BYTE_W +: BYTE_W]),
         .res_byte (lane_res[l]),
         .dot_term (lane_dot[l])
      );
   end

   assign req_accept        = req_ch.valid && in_ready;
   assign merge_ctrl.accept = req_accept;
   assign merge_ctrl.last   = req_ch.last;
   assign merge_ctrl.mode   = mode_ff;
   assign req_ch.ready      = in_ready;

   gvma_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (merge_ctrl),
      .lane_res (lane_res),
      .lane_dot (lane_dot),
      .z_word   (req_ch.z_word),
      .in_ready (in_ready),
      .rsp      (rsp_ch)
   );

`ifndef SYNTHESIS
   // An inner-product beat that is not last must not raise a response
   a_dot_no_beat: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (mode_ff == MODE_DOT) && !req_ch.last) |=> !rsp_ch.valid)
      else $error("response raised for a non-final inner-product beat");

   // Every beat that produces a result shows up in the next cycle
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (req_accept && ((mode_ff != MODE_DOT) || req_ch.last)) |=> rsp_ch.valid)
      else $error("accepted beat produced no response");

   // A stalled response must block new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while response stalled");
`endif

endmodule

FILE: src/gvma_lane.sv
// One byte lane: GF(2^8) multiply and the per-mode result selection.
module gvma_lane import gvma_pkg::*; (
   input  lane_ctrl_type       ctrl,
   input  logic                lane_en,
   input  logic [BYTE_W-1:0]   x_byte,
   input  logic [BYTE_W-1:0]   z_byte,
   output logic [BYTE_W-1:0]   res_byte,
   output logic [BYTE_W-1:0]   dot_term
);

   logic [BYTE_W-1:0] mul_opnd;
   logic [BYTE_W-1:0] product;

   // Share the multiplier: scale by the coefficient, or by z for the inner product
   assign mul_opnd = (ctrl.mode == MODE_DOT) ? z_byte : ctrl.coefficient;
   assign product  = gf_mul(mul_opnd, x_byte);

   always_comb begin
      res_byte = z_byte;
      dot_term = '0;
      if (lane_en) begin
         unique case (ctrl.mode)
            MODE_MUL:    res_byte = product;
            MODE_ADD:    res_byte = z_byte ^ x_byte;
            MODE_MULADD: res_byte = z_byte ^ product;
            MODE_DOT:    dot_term = product;
         endcase
      end
   end

endmodule

FILE: src/gvma_merge.sv
// Merge stage: assembles the result word, folds inner-product terms, holds the output beat.
module gvma_merge import gvma_pkg::*; #(
   parameter int LANES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  merge_ctrl_type                    ctrl,
   input  logic [LANES-1:0][BYTE_W-1:0]      lane_res,
   input  logic [LANES-1:0][BYTE_W-1:0]      lane_dot,
   input  logic [WORD_W-1:0]                 z_word,
   output logic                              in_ready,
   gvma_rsp_if.source                        rsp
);

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [WORD_W-1:0]     out_word_ff;
   logic [WORD_W-1:0]     out_word_in;
   logic                  out_last_ff;
   logic                  out_last_in;
   logic [BYTE_W-1:0]     acc_ff;
   logic [BYTE_W-1:0]     acc_in;
   logic [BYTE_W-1:0]     item_sum;
   logic [BYTE_W-1:0]     dot_total;
   logic [WORD_W-1:0]     lane_word;
   logic                  emit;

   // Bytes past the lane count of this build pass z straight through
   for (genvar b = 0; b < WORD_BYTES; b++) begin : g_byte
      if (b < LANES) begin : g_lane
         assign lane_word[b*BYTE_W +: BYTE_W] = lane_res[b];
      end else begin : g_pass
         assign lane_word[b*BYTE_W +: BYTE_W] = z_word[b*BYTE_W +: BYTE_W];
      end
   end

   always_comb begin
      item_sum = '0;
      for (int l = 0; l < LANES; l++) begin
         item_sum = item_sum ^ lane_dot[l];
      end
   end

   assign dot_total = acc_ff ^ item_sum;
   assign emit      = ctrl.accept && ((ctrl.mode != MODE_DOT) || ctrl.last);
   assign in_ready  = !out_valid_ff || rsp.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.accept && (ctrl.mode == MODE_DOT)) begin
         acc_in = ctrl.last ? '0 : dot_total;
      end
   end

   always_comb begin
      if (ctrl.mode == MODE_DOT) begin
         out_word_in = {{(WORD_W-BYTE_W){1'b0}}, dot_total};
         out_last_in = 1'b1;
      end else begin
         out_word_in = lane_word;
         out_last_in = ctrl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
      end
   end

   // Load payload only when a new beat is emitted; hold it while stalled
   always_ff @(posedge clock) begin
      if (emit) begin
         out_word_ff <= out_word_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_word = out_word_ff;
   assign rsp.is_last     = out_last_ff;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the GF(2^8) region multiply-accumulate engine.
`timescale 1ns / 1ps

module testbench import gvma_pkg::*; ();

   localparam int LANE_TOTAL = 8;
   localparam logic [7:0] FIELD_FOLD = 8'h1D;  // low byte of x^8+x^4+x^3+x^2+1
   localparam logic [63:0] ALL_ONES = {64{1'b1}};

   // Predicts each result beat from accepted request beats and checks the DUT against it
   class gf_region_tracker;
      typedef struct packed {
         logic [63:0] word;
         logic        last;
      } result_beat_type;

      result_beat_type expected_results[$];
      logic [7:0]   coefficient;
      op_mode_type  mode;
      logic [7:0]   dot_sum;
      int           failures;

      function new();
         coefficient = '0;
         mode        = MODE_MUL;
         dot_sum     = '0;
         failures    = 0;
      endfunction

      // Walk the bits of a, doubling b in the field at each step
      function automatic logic [7:0] field_product(logic [7:0] a, logic [7:0] b);
         logic [7:0] prod;
         logic [7:0] dbl;
         prod = '0;
         dbl  = b;
         for (int k = 0; k < 8; k++) begin
            if (a[k]) begin
               prod = prod ^ dbl;
            end
            dbl = dbl[7] ? ({dbl[6:0], 1'b0} ^ FIELD_FOLD) : {dbl[6:0], 1'b0};
         end
         return prod;
      endfunction

      function void set_register(csr_index_type idx, logic [7:0] value);
         if (idx == CSR_COEFF) begin
            coefficient = value;
         end else begin
            mode = op_mode_type'(value[1:0]);
         end
      endfunction

      function void note_request(logic [63:0] x, logic [63:0] z, logic [3:0] count,
                                 logic last);
         int              used;
         logic [63:0]     word;
         logic [7:0]      item_sum;
         logic [7:0]      xb;
         logic [7:0]      zb;
         result_beat_type beat;
         used     = (count > LANE_TOTAL) ? LANE_TOTAL : int'(count);
         word     = z;
         item_sum = '0;
         for (int lane = 0; lane < 8; lane++) begin
            xb = x[lane*8 +: 8];
            zb = z[lane*8 +: 8];
            if (lane < used) begin
               case (mode)
                  MODE_MUL:    word[lane*8 +: 8] = field_product(coefficient, xb);
                  MODE_ADD:    word[lane*8 +: 8] = zb ^ xb;
                  MODE_MULADD: word[lane*8 +: 8] = zb ^ field_product(coefficient, xb);
                  default:     item_sum = item_sum ^ field_product(xb, zb);
               endcase
            end
         end
         if (mode == MODE_DOT) begin
            dot_sum = dot_sum ^ item_sum;
            if (!last) begin
               return;
            end
            beat.word = {56'b0, dot_sum};
            beat.last = 1'b1;
            dot_sum   = '0;
         end else begin
            beat.word = word;
            beat.last = last;
         end
         expected_results.push_back(beat);
      endfunction

      function void check_result(logic [63:0] word, logic last);
         result_beat_type want;
         if (expected_results.size() == 0) begin
            failures++;
            $display("%0t: unexpected result beat, expected none actual %h/%b",
                     $time, word, last);
            return;
         end
         want = expected_results.pop_front();
         if (word !== want.word) begin
            failures++;
            $display("%0t: result_word expected %h actual %h", $time, want.word, word);
         end
         if (last !== want.last) begin
            failures++;
            $display("%0t: is_last expected %b actual %b", $time, want.last, last);
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   src_idle_pct;
   int   sink_idle_pct;

   gf_region_tracker tracker;

   gvma_req_if req_ch ();
   gvma_rsp_if rsp_ch ();
   gvma_csr_if csr_ch ();

   gf256_vector_mul_add #(
      .LANES (LANE_TOTAL)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Take result beats and stall the receiver at random
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_result(rsp_ch.result_word, rsp_ch.is_last);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return ALL_ONES;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Mostly legal counts, biased to a full word, with zero and oversize now and then
   function automatic logic [3:0] random_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         return 4'd0;
      end else if (r < 10) begin
         return 4'($urandom_range(9, 15));
      end else if (r < 40) begin
         return 4'd8;
      end
      return 4'($urandom_range(1, 8));
   endfunction

   task automatic send_item(logic [63:0] x, logic [63:0] z, logic [3:0] count, logic last);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.x_word     <= x;
      req_ch.z_word     <= z;
      req_ch.lane_count <= count;
      req_ch.last       <= last;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      tracker.note_request(x, z, count, last);
   endtask

   // Hold the sender until every result is back, then let the pipeline settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [7:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      tracker.set_register(idx, value);
   endtask

   task automatic configure(logic [7:0] coef, logic [7:0] mode_data);
      drain();
      write_register(CSR_COEFF, coef);
      write_register(CSR_MODE, mode_data);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_directed();
      configure(8'h02, 8'(MODE_MUL));
      send_item(ALL_ONES, '0, 4'd8, 1'b1);
      send_item(64'h0102_0408_1020_4080, random_word(), 4'd8, 1'b0);
      send_item(random_word(), ALL_ONES, 4'd0, 1'b1);
      send_item(random_word(), random_word(), 4'd1, 1'b0);
      send_item(random_word(), random_word(), 4'd15, 1'b1);
      send_item(random_word(), random_word(), 4'd9, 1'b0);
      // zero coefficient: multiply clears valid lanes, multiply-add leaves z
      configure(8'h00, 8'(MODE_MUL));
      send_item(random_word(), random_word(), 4'd8, 1'b1);
      configure(8'h00, 8'(MODE_MULADD));
      send_item(random_word(), random_word(), 4'd8, 1'b0);
      configure(8'hFF, 8'hFC | 8'(MODE_MULADD));
      send_item(ALL_ONES, random_word(), 4'd5, 1'b1);
      send_item(random_word(), random_word(), 4'd7, 1'b0);
      configure(8'h8E, 8'(MODE_ADD));
      send_item(ALL_ONES, ALL_ONES, 4'd8, 1'b1);
      send_item(random_word(), random_word(), 4'd3, 1'b0);
      configure(8'h01, 8'(MODE_DOT));
      send_item(random_word(), random_word(), 4'd8, 1'b0);
      send_item(random_word(), random_word(), 4'd0, 1'b0);
      send_item(random_word(), random_word(), 4'd12, 1'b0);
      send_item(random_word(), random_word(), 4'd4, 1'b1);
      send_item(ALL_ONES, ALL_ONES, 4'd8, 1'b1);
      // partial sum must survive a detour through another mode
      send_item(random_word(), random_word(), 4'd2, 1'b0);
      configure(8'h55, 8'(MODE_ADD));
      send_item(random_word(), random_word(), 4'd8, 1'b1);
      configure(8'hAA, 8'(MODE_DOT));
      send_item(random_word(), random_word(), 4'd8, 1'b1);
      send_item(random_word(), random_word(), 4'd0, 1'b1);
   endtask

   task automatic run_random_phase(int item_target);
      int         sent;
      int         vec_left;
      logic [7:0] coef;
      logic [1:0] mode;
      logic [5:0] pad;
      logic       lst;
      sent = 0;
      while (sent < item_target) begin
         case ($urandom_range(0, 5))
            0:       coef = 8'h00;
            1:       coef = 8'h01;
            2:       coef = 8'hFF;
            default: coef = 8'($urandom_range(0, 255));
         endcase
         mode = 2'($urandom_range(0, 3));
         pad  = 6'($urandom_range(0, 63));
         configure(coef, {pad, mode});
         vec_left = $urandom_range(1, 6);
         repeat ($urandom_range(8, 40)) begin
            if (op_mode_type'(mode) == MODE_DOT) begin
               vec_left--;
               lst = (vec_left == 0);
               // break a vector now and then
               if ($urandom_range(0, 19) == 0) begin
                  lst = ~lst;
               end
               if (vec_left == 0) begin
                  vec_left = $urandom_range(1, 6);
               end
            end else begin
               lst = 1'($urandom_range(0, 1));
            end
            send_item(random_word(), random_word(), random_count(), lst);
            sent++;
         end
      end
   endtask

   initial begin
      tracker           = new();
      src_idle_pct      = 31;
      sink_idle_pct     = 68;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.x_word     <= '0;
      req_ch.z_word     <= '0;
      req_ch.lane_count <= '0;
      req_ch.last       <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= CSR_COEFF;
      csr_ch.data       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random_phase(265);
      src_idle_pct  = 68;
      sink_idle_pct = 31;
      run_random_phase(265);
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      run_random_phase(265);
      drain();

      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: gf256_vector_mul_add.f
src/gvma_pkg.sv
src/gvma_channels.sv
src/gvma_lane.sv
src/gvma_merge.sv
src/gf256_vector_mul_add.sv
tb/testbench.sv
